/* rtl/ugcs_pkg.sv */
// Shared types and constants for the UTF-8 grapheme cluster segmenter.
// No dependencies; every other file refers to it by scoped names.
package ugcs_pkg;

	localparam int MAX_RES    = 4;
	localparam int PEND_DEPTH = 3;
	localparam int CNT_W      = $clog2(MAX_RES + 1);
	localparam int IDX_W      = $clog2(MAX_RES);
	localparam int PIDX_W     = $clog2(PEND_DEPTH);

	typedef enum logic [1:0] {
		MODE_GENERAL   = 2'd0,
		MODE_RI_OPEN   = 2'd1,
		MODE_RI_CLOSED = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       starts_cluster;
		logic       starts_unit;
		logic       text_done;
		logic       run_last;
	} seg_item_t;

	typedef struct packed {
		logic  at_start;
		mode_t mode;
		logic  joiner;
		logic  virama;
		logic  parity;
	} seg_state_t;

	localparam seg_state_t SEG_RESET = '{
		at_start: 1'b1,
		mode:     MODE_GENERAL,
		joiner:   1'b0,
		virama:   1'b0,
		parity:   1'b0
	};

	typedef struct packed {
		logic [PIDX_W-1:0] count;
		logic [2:0]        exp_len;
	} dec_state_t;

	typedef struct packed {
		logic              we;
		logic [PIDX_W-1:0] idx;
	} pend_wr_t;

	typedef struct packed {
		seg_item_t [MAX_RES-1:0] slot;
		logic [CNT_W-1:0]        count;
	} batch_t;

endpackage

/* rtl/ugcs_if.sv */
// Stream interfaces for the segmenter: text bytes in, marked bytes out.
// Depends on ugcs_pkg for the payload types.
interface ugcs_text_if;
	logic                   valid;
	logic                   ready;
	ugcs_pkg::text_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ugcs_seg_if;
	logic                   valid;
	logic                   ready;
	ugcs_pkg::seg_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ugcs_step.sv */
// Combinational decode and cluster decision for one text byte.
// Depends on ugcs_pkg; produces the result batch and next state.
module ugcs_step (
	input  ugcs_pkg::text_item_t                       item,
	input  ugcs_pkg::seg_state_t                       seg,
	input  ugcs_pkg::dec_state_t                       dec,
	input  logic [ugcs_pkg::PEND_DEPTH-1:0][7:0]       pend,
	output ugcs_pkg::batch_t                           batch,
	output ugcs_pkg::seg_state_t                       seg_nxt,
	output ugcs_pkg::dec_state_t                       dec_nxt,
	output ugcs_pkg::pend_wr_t                         pend_wr
);

	localparam logic [20:0] ZWJ_CP = 21'h0200D;
	localparam logic [20:0] RI_LO  = 21'h1F1E6;
	localparam logic [20:0] RI_HI  = 21'h1F1FF;

	typedef struct packed {
		logic ri;
		logic ext;
		logic vir;
		logic zwj;
		logic pict;
	} cls_t;

	typedef struct packed {
		logic                 brk;
		ugcs_pkg::seg_state_t st;
	} step_t;

	function automatic logic in_rng(logic [20:0] cp, logic [20:0] lo, logic [20:0] hi);
		return (cp >= lo) && (cp <= hi);
	endfunction

	function automatic cls_t classify(logic [20:0] cp);
		cls_t c;
		c.vir = (cp == 21'h0094D) || (cp == 21'h009CD) || (cp == 21'h00A4D) ||
			(cp == 21'h00ACD) || (cp == 21'h00B4D) || (cp == 21'h00BCD) ||
			(cp == 21'h00C4D) || (cp == 21'h00CCD) || (cp == 21'h00D4D) ||
			(cp == 21'h00DCA);
		c.zwj = (cp == ZWJ_CP);
		c.ri  = in_rng(cp, RI_LO, RI_HI);
		c.ext = in_rng(cp, 21'h00300, 21'h0036F) || in_rng(cp, 21'h01AB0, 21'h01AFF) ||
			in_rng(cp, 21'h01DC0, 21'h01DFF) || in_rng(cp, 21'h020D0, 21'h020FF) ||
			in_rng(cp, 21'h0FE00, 21'h0FE0F) || in_rng(cp, 21'h0FE20, 21'h0FE2F) ||
			c.zwj || c.vir ||
			in_rng(cp, 21'h1F3FB, 21'h1F3FF) || in_rng(cp, 21'hE0100, 21'hE01EF) ||
			in_rng(cp, 21'h011A8, 21'h011FF) || in_rng(cp, 21'h0D7CB, 21'h0D7FB);
		c.pict = in_rng(cp, 21'h02600, 21'h027BF) || in_rng(cp, 21'h1F300, 21'h1F9FF) ||
			in_rng(cp, 21'h1FA70, 21'h1FAFF);
		return c;
	endfunction

	// Boundary decision for one unit, with the state it leaves behind.
	function automatic step_t unit_step(ugcs_pkg::seg_state_t s, cls_t c);
		step_t r;
		r.st  = s;
		r.brk = 1'b0;
		priority if (s.at_start) begin
			r.brk = 1'b1;
		end else if (s.mode == ugcs_pkg::MODE_RI_OPEN && c.ri) begin
			r.st.mode = ugcs_pkg::MODE_RI_CLOSED;
		end else if (s.mode != ugcs_pkg::MODE_GENERAL) begin
			if (c.ext) begin
				r.st.mode   = ugcs_pkg::MODE_GENERAL;
				r.st.joiner = c.zwj;
				r.st.virama = c.vir;
			end else begin
				r.brk = 1'b1;
			end
		end else if (s.virama) begin
			r.st.virama = c.vir;
		end else if (c.ext) begin
			r.st.joiner = c.zwj;
			r.st.virama = c.vir;
		end else if (s.joiner && c.pict) begin
			r.st.joiner = 1'b0;
		end else begin
			r.brk = 1'b1;
		end
		if (r.brk) begin
			r.st.joiner = 1'b0;
			if (c.ri) begin
				r.st.mode   = s.parity ? ugcs_pkg::MODE_RI_CLOSED : ugcs_pkg::MODE_RI_OPEN;
				r.st.virama = 1'b0;
			end else begin
				r.st.mode   = ugcs_pkg::MODE_GENERAL;
				r.st.virama = c.vir;
			end
		end
		r.st.parity   = c.ri ? !s.parity : 1'b0;
		r.st.at_start = 1'b0;
		return r;
	endfunction

	logic [7:0]                          b;
	logic                                eot;
	logic                                cont;
	logic [2:0]                          len;
	logic [ugcs_pkg::CNT_W-1:0]          pc_ext;
	logic [ugcs_pkg::CNT_W-1:0]          pc_inc;
	logic                                case_a;
	logic                                case_b;
	logic                                a_done;
	logic                                one_unit;
	logic                                emit_new;
	logic [20:0]                         cp;
	cls_t                                cls_raw;
	cls_t                                tail_cls;
	cls_t [ugcs_pkg::MAX_RES-1:0]        ucls;
	logic [ugcs_pkg::MAX_RES-1:0]        su;
	logic [ugcs_pkg::CNT_W-1:0]          n;
	logic [ugcs_pkg::MAX_RES-1:0][7:0]   src;

	assign b    = item.text_byte;
	assign eot  = item.end_of_text;
	assign cont = (b[7:6] == 2'b10);
	assign src  = {b, pend};

	always_comb begin
		priority if (!b[7])                len = 3'd1;
		else if (b[7:5] == 3'b110)         len = 3'd2;
		else if (b[7:4] == 4'b1110)        len = 3'd3;
		else if (b[7:3] == 5'b11110)       len = 3'd4;
		else                               len = 3'd0;
	end

	assign pc_ext   = ugcs_pkg::CNT_W'(dec.count);
	assign pc_inc   = pc_ext + ugcs_pkg::CNT_W'(1);
	assign case_a   = (dec.count != '0) && cont &&
		(pc_ext != ugcs_pkg::CNT_W'(ugcs_pkg::PEND_DEPTH));
	assign case_b   = (pc_ext == ugcs_pkg::CNT_W'(ugcs_pkg::PEND_DEPTH)) && cont;
	assign a_done   = case_a && (3'(pc_inc) == dec.exp_len);
	assign one_unit = a_done || case_b;
	assign emit_new = (len == 3'd1) || (len == 3'd0) || eot;

	// Assemble the scalar of a finished sequence, or take the byte as ASCII.
	always_comb begin
		priority if (case_b)
			cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
		else if (case_a && dec.exp_len == 3'd3)
			cp = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
		else if (case_a)
			cp = {10'd0, pend[0][4:0], b[5:0]};
		else
			cp = {13'd0, b};
	end

	assign cls_raw  = classify(cp);
	assign tail_cls = (!case_a && !case_b && len == 3'd1) ? cls_raw : '0;

	always_comb begin
		priority if (one_unit)  n = pc_inc;
		else if (case_a)        n = eot ? pc_inc : '0;
		else                    n = pc_ext + ugcs_pkg::CNT_W'(emit_new);
	end

	// Walk the units of this byte in order; malformed units classify as nothing.
	always_comb begin
		ugcs_pkg::seg_state_t st;
		step_t                r;
		logic                 live;
		logic                 last;
		st = seg;
		for (int i = 0; i < ugcs_pkg::MAX_RES; i++) begin
			su[i]   = one_unit ? (i == 0) : 1'b1;
			ucls[i] = one_unit ? ((i == 0) ? cls_raw : '0)
				: ((ugcs_pkg::CNT_W'(i) == pc_ext) ? tail_cls : '0);
			r    = unit_step(st, ucls[i]);
			live = (ugcs_pkg::CNT_W'(i) < n) && su[i];
			last = (ugcs_pkg::CNT_W'(i) + ugcs_pkg::CNT_W'(1)) == n;
			if (live)
				st = r.st;
			batch.slot[i].out_byte       = (ugcs_pkg::CNT_W'(i) < pc_ext)
				? src[ugcs_pkg::IDX_W'(i)] : b;
			batch.slot[i].starts_cluster = live && r.brk;
			batch.slot[i].starts_unit    = su[i];
			batch.slot[i].run_last       = last;
			batch.slot[i].text_done      = last && eot;
		end
		batch.count = n;
		seg_nxt     = eot ? ugcs_pkg::SEG_RESET : st;
	end

	always_comb begin
		pend_wr.we  = 1'b0;
		pend_wr.idx = '0;
		dec_nxt     = dec;
		priority if (case_a) begin
			pend_wr.we  = 1'b1;
			pend_wr.idx = dec.count;
			if (a_done)
				dec_nxt = '0;
			else
				dec_nxt.count = ugcs_pkg::PIDX_W'(pc_inc);
		end else if (case_b) begin
			dec_nxt = '0;
		end else if (emit_new) begin
			dec_nxt = '0;
		end else begin
			pend_wr.we      = 1'b1;
			pend_wr.idx     = '0;
			dec_nxt.count   = ugcs_pkg::PIDX_W'(1);
			dec_nxt.exp_len = len;
		end
		if (eot)
			dec_nxt = '0;
	end

endmodule

/* rtl/utf8_grapheme_cluster_segmenter_unit.sv */
// Top level of the UTF-8 grapheme cluster segmenter.
// Depends on ugcs_pkg, ugcs_if (stream interfaces) and ugcs_step.
//
// Channel  Dir  Payload                                            Transaction
// text     in   text_byte, end_of_text                             valid & ready
// segs     out  out_byte, starts_cluster, starts_unit, text_done,  valid & ready
//               run_last
//
// A text byte is decoded and judged in the cycle it is taken; its results (0 to 4)
// land in a four-slot result register and leave one per cycle while segs is ready.
// Sustained rate is one byte per cycle while each byte yields at most one result and segs is ready;
// a byte that yields more results holds text while the slots drain.
// The next byte is taken in the same cycle as the last result of the batch.
// arst_n clears decode and cluster state to the start of a text; no clearing pass.
// A stall on segs holds the batch; text then waits until the last slot goes out.
module utf8_grapheme_cluster_segmenter_unit (
	input  logic          clk,
	input  logic          arst_n,
	ugcs_text_if.sink     text,
	ugcs_seg_if.source    segs
);

	// Pending bytes of an unfinished sequence: payload only, written before read.
	logic [ugcs_pkg::PEND_DEPTH-1:0][7:0]        pend_q;
	ugcs_pkg::dec_state_t                        dec_q;
	ugcs_pkg::seg_state_t                        seg_q;

	// Result register: one batch of results and a drain pointer.
	ugcs_pkg::seg_item_t [ugcs_pkg::MAX_RES-1:0] slot_q;
	logic [ugcs_pkg::CNT_W-1:0]                  bat_cnt_q;
	logic [ugcs_pkg::IDX_W-1:0]                  bat_idx_q;

	ugcs_pkg::batch_t                            batch;
	ugcs_pkg::seg_state_t                        seg_nxt;
	ugcs_pkg::dec_state_t                        dec_nxt;
	ugcs_pkg::pend_wr_t                          pend_wr;

	logic accept;
	logic take;
	logic last_slot;

	ugcs_step u_step (
		.item    (text.data),
		.seg     (seg_q),
		.dec     (dec_q),
		.pend    (pend_q),
		.batch   (batch),
		.seg_nxt (seg_nxt),
		.dec_nxt (dec_nxt),
		.pend_wr (pend_wr)
	);

	// The slot on show is the last one of its batch.
	assign last_slot = (ugcs_pkg::CNT_W'(bat_idx_q) + ugcs_pkg::CNT_W'(1)) == bat_cnt_q;
	assign take      = segs.valid && segs.ready;

	// Take a new byte when the batch is empty or its last result leaves now.
	assign text.ready = (bat_cnt_q == '0) || (segs.ready && last_slot);
	assign accept     = text.valid && text.ready;

	assign segs.valid = (bat_cnt_q != '0);
	assign segs.data  = slot_q[bat_idx_q];

	// Store the byte into the pending line when it extends or opens a sequence.
	always_ff @(posedge clk) begin
		if (accept && pend_wr.we)
			pend_q[pend_wr.idx] <= text.data.text_byte;
	end

	// Load a fresh batch; slots of an empty batch are never shown.
	always_ff @(posedge clk) begin
		if (accept)
			slot_q <= batch.slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= '0;
			seg_q <= ugcs_pkg::SEG_RESET;
		end else if (accept) begin
			dec_q <= dec_nxt;
			seg_q <= seg_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_cnt_q <= '0;
			bat_idx_q <= '0;
		end else if (accept) begin
			bat_cnt_q <= batch.count;
			bat_idx_q <= '0;
		end else if (take) begin
			if (last_slot) begin
				bat_cnt_q <= '0;
				bat_idx_q <= '0;
			end else begin
				bat_idx_q <= bat_idx_q + ugcs_pkg::IDX_W'(1);
			end
		end
	end

	// End of text always flushes and returns to the start of a text.
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.data.end_of_text |=> seg_q.at_start && dec_q.count == '0)
		else $error("end of text did not restore the text start state");

	// End of text always produces at least one result.
	a_eot_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.data.end_of_text |-> batch.count != '0)
		else $error("end of text produced no result");

	// A pending sequence is always shorter than its expected length.
	a_pend_short: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.count != '0 |-> 3'(dec_q.count) < dec_q.exp_len)
		else $error("pending count reached expected length");

	// The drain pointer stays inside the batch.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bat_cnt_q != '0 |-> ugcs_pkg::CNT_W'(bat_idx_q) < bat_cnt_q)
		else $error("result pointer beyond batch");

	// Only the final slot of a batch carries run_last.
	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		segs.valid |-> segs.data.run_last == last_slot)
		else $error("run_last does not mark the end of the batch");

endmodule
